// ----- rtl/layer_ordered_insert_list_unit_defines.svh -----
// Assertion macros shared by the layer ordered insert list RTL.
`ifndef LAYER_ORDERED_INSERT_LIST_UNIT_DEFINES_SVH
`define LAYER_ORDERED_INSERT_LIST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LOIL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LOIL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/loil_pkg.sv -----
// Types and constants shared by the layer ordered insert list modules.
package loil_pkg;

   localparam int DataW        = 16;
   localparam int PosW         = 4;
   localparam int StatusW      = 2;
   localparam int DefaultDepth = 16;
   localparam int MaxResults   = 16;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_DUMP   = 1'b1;

   typedef struct packed {
      logic capture;
      logic insert;
      logic dump_step;
   } cmd_type;

   typedef struct packed {
      logic req_dump;
      logic emit;
      logic final_step;
   } sts_type;

endpackage

// ----- rtl/loil_req_if.sv -----
// Request channel carrying insert and dump items.
interface loil_req_if import loil_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [DataW-1:0]        item_id;
   logic signed [DataW-1:0] layer;

   modport source (output valid, action, item_id, layer, input ready);
   modport sink (input valid, action, item_id, layer, output ready);
endinterface

// ----- rtl/loil_rsp_if.sv -----
// Response channel carrying result items.
interface loil_rsp_if import loil_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DataW-1:0]        out_id;
   logic signed [DataW-1:0] out_layer;
   logic [PosW-1:0]         position;
   logic                    last;
   logic [StatusW-1:0]      status;

   modport source (output valid, out_id, out_layer, position, last, status, input ready);
   modport sink (input valid, out_id, out_layer, position, last, status, output ready);
endinterface

// ----- rtl/loil_ctrl.sv -----
// Controller state machine that sequences inserts and dumps.
`include "layer_ordered_insert_list_unit_defines.svh"

module loil_ctrl import loil_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts_i,
   output cmd_type cmd_o
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      load;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      load      = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.capture = 1'b1;
               state_in      = sts_i.req_dump ? S_DUMP : S_INS;
            end
         end
         S_INS: begin
            if (slot_free) begin
               cmd_o.insert = 1'b1;
               load         = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DUMP: begin
            if (!sts_i.emit || slot_free) begin
               cmd_o.dump_step = 1'b1;
               load            = sts_i.emit;
               if (sts_i.final_step) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LOIL_ASSERT_IMPL(a_no_overwrite, cmd_o.insert || (cmd_o.dump_step && sts_i.emit), slot_free, "result register overwritten while waiting")
   `LOIL_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "new item accepted while one is in progress")

endmodule

// ----- rtl/loil_dp.sv -----
// Datapath with the compare-and-shift entry row, dump counter and result register.
`include "layer_ordered_insert_list_unit_defines.svh"

module loil_dp import loil_pkg::*; #(
   parameter int DEPTH = DefaultDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd_i,
   output sts_type                 sts_o,
   input  logic                    in_action,
   input  logic [DataW-1:0]        in_item_id,
   input  logic signed [DataW-1:0] in_layer,
   output logic [DataW-1:0]        out_id,
   output logic signed [DataW-1:0] out_layer,
   output logic [PosW-1:0]         out_position,
   output logic                    out_last,
   output logic [StatusW-1:0]      out_status
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic signed [DataW-1:0] key_ff [DEPTH];
   logic signed [DataW-1:0] key_in [DEPTH];
   logic [DataW-1:0]        id_ff [DEPTH];
   logic [DataW-1:0]        id_in [DEPTH];
   logic [DEPTH-1:0]        le_ff, le_in, at;
   logic [CW-1:0]           count_ff, count_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [DataW-1:0]        rid_ff, rid_in;
   logic signed [DataW-1:0] rkey_ff, rkey_in;
   logic [DataW-1:0]        oid_ff, oid_in;
   logic signed [DataW-1:0] olayer_ff, olayer_in;
   logic [PosW-1:0]         opos_ff, opos_in;
   logic                    olast_ff, olast_in;
   status_type              ostat_ff, ostat_in;
   logic                    full, empty, emit, last_step;
   logic [IW-1:0]           ins_pos;
   logic [CW-1:0]           last_idx;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le_in[i] = (CW'(i) < count_ff) && (key_ff[i] <= in_layer);
      end
      at[0] = !le_ff[0];
      for (int i = 1; i < DEPTH; i++) begin
         at[i] = !le_ff[i] && le_ff[i-1];
      end
      ins_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ins_pos = ins_pos | (at[i] ? IW'(i) : '0);
      end
   end

   always_comb begin
      if (int'(count_ff) > MaxResults) begin
         last_idx = CW'(MaxResults - 1);
      end else begin
         last_idx = count_ff - CW'(1);
      end
      emit      = empty || (int'(idx_ff) < MaxResults);
      last_step = empty || (CW'(idx_ff) == last_idx);
   end

   assign sts_o.req_dump   = (in_action == ACTION_DUMP);
   assign sts_o.emit       = emit;
   assign sts_o.final_step = empty || (CW'(idx_ff) == count_ff - CW'(1));

   always_comb begin
      key_in    = key_ff;
      id_in     = id_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      rid_in    = rid_ff;
      rkey_in   = rkey_ff;
      oid_in    = oid_ff;
      olayer_in = olayer_ff;
      opos_in   = opos_ff;
      olast_in  = olast_ff;
      ostat_in  = ostat_ff;
      if (cmd_i.capture) begin
         rid_in  = in_item_id;
         rkey_in = in_layer;
         idx_in  = '0;
      end
      if (cmd_i.insert) begin
         oid_in    = rid_ff;
         olayer_in = rkey_ff;
         olast_in  = 1'b1;
         if (full) begin
            opos_in  = '0;
            ostat_in = STATUS_FULL;
         end else begin
            opos_in  = PosW'(ins_pos);
            ostat_in = STATUS_OK;
            count_in = count_ff + CW'(1);
            if (at[0]) begin
               key_in[0] = rkey_ff;
               id_in[0]  = rid_ff;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (at[i]) begin
                  key_in[i] = rkey_ff;
                  id_in[i]  = rid_ff;
               end else if (!le_ff[i]) begin
                  key_in[i] = key_ff[i-1];
                  id_in[i]  = id_ff[i-1];
               end
            end
         end
      end
      if (cmd_i.dump_step) begin
         idx_in = idx_ff + IW'(1);
         if (emit) begin
            olast_in = last_step;
            if (empty) begin
               oid_in    = '0;
               olayer_in = '0;
               opos_in   = '0;
               ostat_in  = STATUS_EMPTY;
            end else begin
               oid_in    = id_ff[0];
               olayer_in = key_ff[0];
               opos_in   = PosW'(idx_ff);
               ostat_in  = STATUS_OK;
            end
         end
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (CW'(i + 1) < count_ff) begin
               key_in[i] = key_ff[i+1];
               id_in[i]  = id_ff[i+1];
            end else if (CW'(i + 1) == count_ff) begin
               key_in[i] = key_ff[0];
               id_in[i]  = id_ff[0];
            end
         end
         if (full) begin
            key_in[DEPTH-1] = key_ff[0];
            id_in[DEPTH-1]  = id_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      id_ff     <= id_in;
      idx_ff    <= idx_in;
      rid_ff    <= rid_in;
      rkey_ff   <= rkey_in;
      oid_ff    <= oid_in;
      olayer_ff <= olayer_in;
      opos_ff   <= opos_in;
      olast_ff  <= olast_in;
      ostat_ff  <= ostat_in;
      if (cmd_i.capture) begin
         le_ff <= le_in;
      end
   end

   assign out_id       = oid_ff;
   assign out_layer    = olayer_ff;
   assign out_position = opos_ff;
   assign out_last     = olast_ff;
   assign out_status   = ostat_ff;

   `LOIL_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= CW'(DEPTH), "entry count exceeds depth")
   `LOIL_ASSERT_NEXT(a_insert_count, cmd_i.insert && !full, count_ff == $past(count_ff) + CW'(1), "insert did not add one entry")
   `LOIL_ASSERT_IMPL(a_one_slot, cmd_i.insert && !full, $onehot(at), "insert slot is not unique")

endmodule

// ----- rtl/layer_ordered_insert_list_unit.sv -----
// Top level of the layer ordered insert list.
// The block keeps up to DEPTH entries, each an item id with a signed layer key,
// sorted by ascending layer; equal layers keep their arrival order.
// Request items arrive on req_chan: action 0 inserts item_id at layer, action 1
// dumps the list. An insert gives one result with its rank, or a full status
// if the list already holds DEPTH entries. A dump emits the stored entries in
// rank order, up to sixteen, with last on the final one; an empty list gives
// one result with an empty status.
// For an insert the compare row is registered at acceptance, and the shift
// happens in S_INS together with the load of the result register, once that
// register is free. A dump steps once through every stored entry, or once
// for an empty list, rotating the entry row, which leaves the list in its
// original order.
// Results leave through a single output register on rsp_chan; while it waits
// the block still accepts a request, and further work pauses until rsp_chan
// takes the pending result. Synchronous reset empties the list and drops any
// pending result; entry contents need no clearing.
module layer_ordered_insert_list_unit import loil_pkg::*; #(
   parameter int DEPTH = DefaultDepth
) (
   input  logic       clock,
   input  logic       reset,
   loil_req_if.sink   req_chan,
   loil_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   loil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   loil_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (cmd),
      .sts_o        (sts),
      .in_action    (req_chan.action),
      .in_item_id   (req_chan.item_id),
      .in_layer     (req_chan.layer),
      .out_id       (rsp_chan.out_id),
      .out_layer    (rsp_chan.out_layer),
      .out_position (rsp_chan.position),
      .out_last     (rsp_chan.last),
      .out_status   (rsp_chan.status)
   );

endmodule
